[hdl/drcs_pkg.sv]
// Shared types and constants for the Diameter Result-Code scanner.
package drcs_pkg;

    localparam int unsigned HEADER_BYTES = 20;

    localparam logic [31:0] RC_ATTR_CODE    = 32'd268;
    localparam logic [23:0] RC_MIN_LENGTH   = 24'd12;
    localparam logic [23:0] MIN_ATTR_LENGTH = 24'd8;
    localparam logic [24:0] PAD_MASK        = 25'd3;

    // Byte offsets inside one attribute
    localparam logic [3:0] OFF_FLAGS     = 4'd4;
    localparam logic [3:0] OFF_LEN_LAST  = 4'd7;
    localparam logic [3:0] OFF_VAL_FIRST = 4'd8;
    localparam logic [3:0] OFF_VAL_LAST  = 4'd11;
    localparam logic [3:0] ATTR_HDR_END  = 4'd12;

    typedef struct packed {
        logic [31:0] code;
        logic        found;
        logic        malformed;
    } t_scan_result;

endpackage

[hdl/drcs_parser.sv]
// Byte-wise attribute walker: position tracking, attribute header capture, value capture.
module drcs_parser #(
    parameter int POSITION_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output drcs_pkg::t_scan_result o_result
);

    localparam int SUM_BITS = ((POSITION_BITS > 25) ? POSITION_BITS : 25) + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] START_RST =
        POSITION_BITS'(drcs_pkg::HEADER_BYTES);
    localparam int ATTR_HDR_END_W = int'(drcs_pkg::ATTR_HDR_END);

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [31:0]              r_code, n_code;
    logic [23:0]              r_len, n_len;
    logic [31:0]              r_value, n_value;
    logic                     r_match, n_match;
    logic                     r_found, n_found;
    logic                     r_stop, n_stop;

    logic [POSITION_BITS:0]   diff;
    logic                     in_attr;
    logic                     parse;
    logic [3:0]               off;
    logic [23:0]              len_new;
    logic [24:0]              padded;
    logic [SUM_BITS-1:0]      start_sum;

    always_comb begin
        diff    = {1'b0, r_pos} - {1'b0, r_start};
        in_attr = !diff[POSITION_BITS]
                  && (diff[POSITION_BITS-1:0] < POSITION_BITS'(ATTR_HDR_END_W));
        off     = diff[3:0];
        parse   = (r_pos != POS_MAX) && !r_found && !r_stop && in_attr;
        len_new = {r_len[15:0], i_byte};
        padded  = ({1'b0, len_new} + drcs_pkg::PAD_MASK) & ~drcs_pkg::PAD_MASK;
        start_sum = SUM_BITS'(r_start) + SUM_BITS'(padded);

        n_pos   = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
        n_start = r_start;
        n_code  = r_code;
        n_len   = r_len;
        n_value = r_value;
        n_match = r_match;
        n_found = r_found;
        n_stop  = r_stop;

        if (parse) begin
            if (off < drcs_pkg::OFF_FLAGS) begin
                n_code = {r_code[23:0], i_byte};
            end else if (off > drcs_pkg::OFF_FLAGS && off <= drcs_pkg::OFF_LEN_LAST) begin
                n_len = len_new;
                if (off == drcs_pkg::OFF_LEN_LAST) begin
                    if (len_new < drcs_pkg::MIN_ATTR_LENGTH) begin
                        n_stop = 1'b1;
                    end else if (r_code == drcs_pkg::RC_ATTR_CODE
                                 && len_new >= drcs_pkg::RC_MIN_LENGTH) begin
                        n_match = 1'b1;
                    end else if (start_sum >= SUM_BITS'(POS_MAX)) begin
                        // beyond reach of the position counter: never parsed again
                        n_start = POS_MAX;
                    end else begin
                        n_start = start_sum[POSITION_BITS-1:0];
                    end
                end
            end else if (off >= drcs_pkg::OFF_VAL_FIRST && r_match) begin
                n_value = {r_value[23:0], i_byte};
                if (off == drcs_pkg::OFF_VAL_LAST) begin
                    n_found = 1'b1;
                end
            end
        end

        o_result.code      = n_found ? n_value : 32'd0;
        o_result.found     = n_found;
        o_result.malformed = n_stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos   <= '0;
            r_start <= START_RST;
            r_code  <= '0;
            r_len   <= '0;
            r_value <= '0;
            r_match <= 1'b0;
            r_found <= 1'b0;
            r_stop  <= 1'b0;
        end else if (i_en) begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_code  <= n_code;
            r_len   <= n_len;
            r_value <= n_value;
            r_match <= n_match;
            r_found <= n_found;
            r_stop  <= n_stop;
        end
    end

    property p_found_needs_match;
        @(posedge i_clk) disable iff (!i_rst_n) r_found |-> r_match;
    endproperty
    a_found_needs_match: assert property (p_found_needs_match)
        else $error("value captured without a matching attribute");

    property p_start_not_behind;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_en && !i_last && n_start != r_start) |=> (r_start > $past(r_start));
    endproperty
    a_start_not_behind: assert property (p_start_not_behind)
        else $error("next attribute start moved backwards");

    property p_flags_exclusive;
        @(posedge i_clk) disable iff (!i_rst_n) !(r_found && r_stop);
    endproperty
    a_flags_exclusive: assert property (p_flags_exclusive)
        else $error("found and malformed both set");

endmodule

[hdl/diameter_result_code_scanner_top.sv]
// Top level of the Diameter Result-Code scanner: stream ports and result register.
//
// Usage:
//   Feed one Diameter message byte per transfer on the slave stream; tlast marks
//   the final byte. The 20-byte header is skipped, then the attribute list is
//   walked. On the transfer that carries tlast exactly one result transfer is
//   produced on the master stream: the Result-Code value (0 when none was fully
//   captured), a found flag and a malformed flag (attribute length below 8).
//   Bytes without tlast produce no result.
// Timing:
//   One byte per cycle while tready is high. The result is registered and
//   appears in the cycle after the tlast transfer. Each byte is handled by
//   one subtract and compare against the next attribute start plus two adds
//   for the padded length and next start, between scan state and result register.
// Reset and stalls:
//   Reset clears the scan state and drops the result valid. After each tlast
//   the scan state returns to its reset values for the next message. While a
//   result waits for the receiver, input is still taken in the same cycle the
//   result leaves; otherwise tready stays low until the result is taken.
module diameter_result_code_scanner_top #(
    parameter int POSITION_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] msg_byte
    input  logic        i_s_axis_tlast,   // last_byte
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] result_code
    output logic [1:0]  o_m_axis_tuser    // [0] code_found, [1] malformed
);

    logic                   in_xfer;
    drcs_pkg::t_scan_result scan_res;
    drcs_pkg::t_scan_result r_res;
    logic                   r_out_valid;

    // Take a byte whenever the result register is empty or emptying
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    drcs_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (in_xfer),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_result (scan_res)
    );

    // Result register: load on the tlast transfer, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && i_s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_s_axis_tlast) begin
            r_res <= scan_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_res.code;
    assign o_m_axis_tuser  = {r_res.malformed, r_res.found};

    property p_last_gives_result;
        @(posedge i_clk) disable iff (!i_rst_n)
            (in_xfer && i_s_axis_tlast) |=> o_m_axis_tvalid;
    endproperty
    a_last_gives_result: assert property (p_last_gives_result)
        else $error("tlast transfer produced no result");

    property p_zero_when_not_found;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 32'd0);
    endproperty
    a_zero_when_not_found: assert property (p_zero_when_not_found)
        else $error("non-zero result code without found flag");

    property p_no_result_without_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!o_m_axis_tvalid && !(in_xfer && i_s_axis_tlast)) |=> !o_m_axis_tvalid;
    endproperty
    a_no_result_without_last: assert property (p_no_result_without_last)
        else $error("result appeared without a tlast transfer");

endmodule
